FILE: hdl/wra_pkg.sv
// Shared types, widths and the log2 mantissa table of the weighted rendezvous argmax.
// No dependencies.
package wra_pkg;

    localparam int HASH_W   = 64;
    localparam int WEIGHT_W = 16;
    localparam int IDENT_W  = 16;
    localparam int FRAC_BITS = 20;
    localparam int MANT_W   = FRAC_BITS + 1;
    localparam int DIFF_W   = 16;
    localparam int DIST_W   = 27;
    localparam int PROD_W   = WEIGHT_W + DIST_W;
    localparam int LEAD_W   = 6;
    localparam int IDX_W    = 5;
    localparam int TAB_N    = 33;

    localparam logic [DIST_W-1:0] DIST_ZERO_HASH = DIST_W'(64) << FRAC_BITS;

    localparam logic [MANT_W-1:0] LOG2_MANT [TAB_N] = '{
        21'd0,       21'd46551,   21'd91711,   21'd135563,  21'd178179,
        21'd219628,  21'd259971,  21'd299266,  21'd337566,  21'd374920,
        21'd411375,  21'd446971,  21'd481749,  21'd515745,  21'd548995,
        21'd581529,  21'd613378,  21'd644570,  21'd675132,  21'd705089,
        21'd734464,  21'd763280,  21'd791557,  21'd819315,  21'd846573,
        21'd873348,  21'd899658,  21'd925518,  21'd950944,  21'd975949,
        21'd1000547, 21'd1024752, 21'd1048576
    };

    typedef struct packed {
        logic load;
        logic norm1;
        logic norm2;
        logic lookup;
        logic mul;
        logic dterm;
        logic prep;
        logic decide;
    } t_dp_cmd;

    typedef struct packed {
        logic elig;
        logic last;
    } t_dp_status;

endpackage

FILE: hdl/wra_if.sv
// Valid/ready channel interfaces for candidate words and result words.
// Depends on wra_pkg.
interface wra_in_if;
    import wra_pkg::*;
    logic                valid;
    logic                ready;
    logic [HASH_W-1:0]   mixed_hash;
    logic [WEIGHT_W-1:0] weight;
    logic [IDENT_W-1:0]  node_ident;
    logic                eligible;
    logic                last_node;

    modport source(output valid, mixed_hash, weight, node_ident, eligible, last_node,
                   input ready);
    modport sink(input valid, mixed_hash, weight, node_ident, eligible, last_node,
                 output ready);
endinterface

interface wra_out_if;
    import wra_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDENT_W-1:0] owner_ident;
    logic               found;

    modport source(output valid, owner_ident, found, input ready);
    modport sink(input valid, owner_ident, found, output ready);
endinterface

FILE: hdl/weighted_rendezvous_argmax.sv
// Top level of the weighted rendezvous argmax: controller, datapath and channel hookup.
// Depends on wra_pkg, wra_if, wra_ctrl and wra_datapath.
//
// One candidate node is taken per input word and the block then works on it alone:
// an eligible node goes through two normalize steps, table lookup, interpolation
// multiply, distance, cross multiply and decide before the next word can be taken;
// an ineligible node goes through the first normalize step and decide only. The
// controller sequence sets these steps. On a word with last_node set, the winner id and found flag are loaded
// into the result register; it waits there while the next key's words are taken,
// and only a second last word finding it still untaken holds the block.
module weighted_rendezvous_argmax (
    input logic       i_clk,
    input logic       i_rst_n,
    wra_in_if.sink    i_in,
    wra_out_if.source o_out
);
    import wra_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    wra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wra_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_mixed_hash  (i_in.mixed_hash),
        .i_weight      (i_in.weight),
        .i_node_ident  (i_in.node_ident),
        .i_eligible    (i_in.eligible),
        .i_last_node   (i_in.last_node),
        .o_owner_ident (o_out.owner_ident),
        .o_found       (o_out.found)
    );
endmodule

FILE: hdl/wra_datapath.sv
// Datapath: leading-one normalize, log2 table interpolation, distance term,
// cross-multiplied compare and best-node registers. Depends on wra_pkg.
module wra_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  wra_pkg::t_dp_cmd         i_cmd,
    output wra_pkg::t_dp_status      o_status,
    input  logic [wra_pkg::HASH_W-1:0]   i_mixed_hash,
    input  logic [wra_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [wra_pkg::IDENT_W-1:0]  i_node_ident,
    input  logic                     i_eligible,
    input  logic                     i_last_node,
    output logic [wra_pkg::IDENT_W-1:0]  o_owner_ident,
    output logic                     o_found
);
    import wra_pkg::*;

    logic [HASH_W-1:0]   r_hash;
    logic [WEIGHT_W-1:0] r_w;
    logic [IDENT_W-1:0]  r_id;
    logic                r_elig;
    logic                r_last;
    logic                r_zero;
    logic [2:0]          r_lb;
    logic [HASH_W-1:0]   r_norm;
    logic [LEAD_W-1:0]   r_lead;
    logic [MANT_W-1:0]   r_lo;
    logic [DIFF_W-1:0]   r_diff;
    logic [FRAC_BITS-1:0] r_rem;
    logic [MANT_W-1:0]   r_frac;
    logic [DIST_W-1:0]   r_dist;
    logic [PROD_W-1:0]   r_left;
    logic [PROD_W-1:0]   r_right;
    logic [WEIGHT_W-1:0] r_best_w;
    logic [DIST_W-1:0]   r_best_dist;
    logic [IDENT_W-1:0]  r_best_id;
    logic                r_have;
    logic [IDENT_W-1:0]  r_owner;
    logic                r_found;

    logic [2:0]          lead_byte;
    logic [2:0]          lead_bit;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W:0]      idx_hi;
    logic [MANT_W-1:0]   mant_lo;
    logic [MANT_W-1:0]   mant_hi;
    logic [DIFF_W+FRAC_BITS-1:0] interp;
    logic [DIST_W-1:0]   whole;
    logic                win;
    logic                take;
    logic                n_have;
    logic [IDENT_W-1:0]  n_best_id;

    always_comb begin
        lead_byte = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_hash[i*8 +: 8] != 8'd0) begin
                lead_byte = 3'(i);
            end
        end
        lead_bit = '0;
        for (int j = 0; j < 8; j++) begin
            if (r_norm[HASH_W-8+j]) begin
                lead_bit = 3'(j);
            end
        end
    end

    assign idx     = r_norm[62:58];
    assign idx_hi  = {1'b0, idx} + (IDX_W+1)'(1);
    assign mant_lo = LOG2_MANT[{1'b0, idx}];
    assign mant_hi = LOG2_MANT[idx_hi];
    assign interp  = r_diff * r_rem;
    assign whole   = {7'd64 - {1'b0, r_lead}, {FRAC_BITS{1'b0}}};

    assign win       = !r_have || (r_left > r_right)
                       || ((r_left == r_right) && (r_id > r_best_id));
    assign take      = r_elig && win;
    assign n_have    = r_have || take;
    assign n_best_id = take ? r_id : r_best_id;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hash <= i_mixed_hash;
            r_w    <= i_weight;
            r_id   <= i_node_ident;
            r_elig <= i_eligible;
            r_last <= i_last_node;
        end
        if (i_cmd.norm1) begin
            r_zero <= (r_hash == '0);
            r_lb   <= lead_byte;
            r_norm <= r_hash << {~lead_byte, 3'b000};
        end
        if (i_cmd.norm2) begin
            r_lead <= {r_lb, lead_bit};
            r_norm <= r_norm << ~lead_bit;
        end
        if (i_cmd.lookup) begin
            r_lo   <= mant_lo;
            r_diff <= DIFF_W'(mant_hi - mant_lo);
            r_rem  <= r_norm[57:38];
        end
        if (i_cmd.mul) begin
            r_frac <= r_lo + MANT_W'(interp >> FRAC_BITS);
        end
        if (i_cmd.dterm) begin
            r_dist <= r_zero ? DIST_ZERO_HASH : (whole - {{(DIST_W-MANT_W){1'b0}}, r_frac});
        end
        if (i_cmd.prep) begin
            r_left  <= r_w * r_best_dist;
            r_right <= r_best_w * r_dist;
        end
        if (i_cmd.decide && r_last) begin
            r_owner <= n_have ? n_best_id : '0;
            r_found <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_w    <= '0;
            r_best_dist <= '0;
            r_best_id   <= '0;
            r_have      <= 1'b0;
        end else if (i_cmd.decide) begin
            if (r_last) begin
                r_best_w    <= '0;
                r_best_dist <= '0;
                r_best_id   <= '0;
                r_have      <= 1'b0;
            end else if (take) begin
                r_best_w    <= r_w;
                r_best_dist <= r_dist;
                r_best_id   <= r_id;
                r_have      <= 1'b1;
            end
        end
    end

    assign o_status.elig = r_elig;
    assign o_status.last = r_last;
    assign o_owner_ident = r_owner;
    assign o_found       = r_found;

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.dterm) && !i_cmd.dterm |-> (r_dist != '0) && (r_dist <= DIST_ZERO_HASH))
        else $error("distance term out of range");

    a_norm_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.norm2) && !r_zero |-> r_norm[HASH_W-1])
        else $error("normalized hash lacks leading one");
endmodule

FILE: hdl/wra_ctrl.sv
// Controller: steps one candidate word through the datapath stages and owns
// the input ready and result valid handshakes. Depends on wra_pkg.
module wra_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  wra_pkg::t_dp_status i_status,
    output wra_pkg::t_dp_cmd    o_cmd
);
    import wra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_NORM1, S_NORM2, S_LOOKUP, S_MUL, S_DIST, S_PREP, S_DECIDE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_busy;

    assign out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = out_busy;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_NORM1;
                end
            end
            S_NORM1: begin
                o_cmd.norm1 = 1'b1;
                n_state     = i_status.elig ? S_NORM2 : S_DECIDE;
            end
            S_NORM2: begin
                o_cmd.norm2 = 1'b1;
                n_state     = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIST;
            end
            S_DIST: begin
                o_cmd.dterm = 1'b1;
                n_state     = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                if (!(i_status.last && out_busy)) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                    if (i_status.last) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decide && i_status.last |-> !out_busy)
        else $error("result overwritten before it was taken");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_NORM1))
        else $error("accepted word did not start");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.decide) && $past(i_status.last))
        else $error("result raised without a last word");
endmodule
